@@ rtl/core/sfd_pkg.sv @@
// Shared types and constants for the sensor frame deframer.
package sfd_pkg;

   localparam int RANGE_SENSORS = 8;
   localparam int FLAG_BYTES    = 2;
   localparam int STAGE_DEPTH   = 8;
   localparam int HDR_DEPTH     = 3;

   localparam logic [7:0] SYNC_FIRST  = 8'h55;
   localparam logic [7:0] SYNC_SECOND = 8'hAA;
   localparam logic [7:0] SUM_SEED    = 8'hFF;
   localparam logic [6:0] LEN_EXTRA   = 7'd4;

   localparam logic [7:0] CMD_RANGE   = 8'h30;
   localparam logic [7:0] CMD_HEADING = 8'h34;
   localparam logic [7:0] CMD_FLAGS   = 8'h36;
   localparam logic [7:0] CMD_NOP_21  = 8'h21;
   localparam logic [7:0] CMD_NOP_24  = 8'h24;
   localparam logic [7:0] CMD_NOP_25  = 8'h25;
   localparam logic [7:0] CMD_NOP_26  = 8'h26;
   localparam logic [7:0] CMD_NOP_2C  = 8'h2C;
   localparam logic [7:0] CMD_NOP_2D  = 8'h2D;
   localparam logic [7:0] CMD_NOP_2F  = 8'h2F;

   typedef enum logic [1:0] {
      RES_ACCEPTED = 2'd0,
      RES_CHECKSUM = 2'd1,
      RES_UNKNOWN  = 2'd2
   } frame_result_type;

   typedef struct packed {
      frame_result_type frame_result;
      logic [7:0]       node_address;
      logic [1:0]       link_status;
      logic [7:0]       command_code;
      logic [5:0]       payload_length;
      logic [63:0]      range_readings;
      logic [15:0]      heading_raw;
      logic [15:0]      obstacle_flags;
   } sfd_result_type;

   localparam int RESULT_BITS = 122;
   localparam int RSP_BITS    = 128;

endpackage

@@ rtl/core/sfd_parser.sv @@
// Frame parser: sync hunt, header and payload capture, checksum and command decode.
module sfd_parser
   import sfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           byte_valid,
   input  logic [7:0]     byte_data,
   input  logic           byte_take,
   output logic           frame_done,
   output sfd_result_type result
);

   logic [7:0] prev_ff, prev_in;
   logic       in_frame_ff, in_frame_in;
   logic [6:0] idx_ff, idx_in;
   logic [6:0] total_ff, total_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] hdr_ff [HDR_DEPTH];
   logic [7:0] hdr_in [HDR_DEPTH];
   logic [7:0] stage_ff [STAGE_DEPTH];
   logic [7:0] stage_in [STAGE_DEPTH];
   logic [7:0] range_ff [RANGE_SENSORS];
   logic [7:0] range_in [RANGE_SENSORS];
   logic [15:0] heading_ff, heading_in;
   logic [15:0] flag_ff, flag_in;

   logic [7:0]  hdr_cur [HDR_DEPTH];
   logic [7:0]  stage_cur [STAGE_DEPTH];
   logic [6:0]  total_cur;
   logic [6:0]  idx_next;
   logic [6:0]  stage_off;
   logic        done;
   logic        sum_ok;
   logic [7:0]  cmd;
   frame_result_type res_code;
   logic [63:0] range_flat;

   always_comb begin
      stage_off = idx_ff - 7'd3;
      for (int i = 0; i < HDR_DEPTH; i++) begin
         hdr_cur[i] = hdr_ff[i];
      end
      if (idx_ff < 7'd3) begin
         hdr_cur[idx_ff[1:0]] = byte_data;
      end
      for (int i = 0; i < STAGE_DEPTH; i++) begin
         stage_cur[i] = stage_ff[i];
      end
      if (idx_ff >= 7'd3 && stage_off < 7'd8) begin
         stage_cur[stage_off[2:0]] = byte_data;
      end
      total_cur = (idx_ff == 7'd1) ? ({1'b0, byte_data[5:0]} + LEN_EXTRA) : total_ff;
      idx_next  = idx_ff + 7'd1;
      done      = in_frame_ff && (idx_next == total_cur);
      sum_ok    = (byte_data == sum_ff);
      cmd       = hdr_cur[2];
   end

   always_comb begin
      for (int i = 0; i < RANGE_SENSORS; i++) begin
         range_in[i] = range_ff[i];
      end
      heading_in = heading_ff;
      flag_in    = flag_ff;
      res_code   = RES_ACCEPTED;
      if (!sum_ok) begin
         res_code = RES_CHECKSUM;
      end else begin
         case (cmd)
            CMD_RANGE: begin
               for (int i = 0; i < RANGE_SENSORS; i++) begin
                  range_in[i] = stage_cur[i];
               end
            end
            CMD_HEADING: begin
               heading_in = {stage_cur[2], stage_cur[3]};
            end
            CMD_FLAGS: begin
               for (int i = 0; i < FLAG_BYTES; i++) begin
                  for (int k = 0; k < 8; k++) begin
                     flag_in[8 * i + 7 - k] = ~stage_cur[i][k];
                  end
               end
            end
            CMD_NOP_21, CMD_NOP_24, CMD_NOP_25, CMD_NOP_26,
            CMD_NOP_2C, CMD_NOP_2D, CMD_NOP_2F: begin
               res_code = RES_ACCEPTED;
            end
            default: begin
               res_code = RES_UNKNOWN;
            end
         endcase
      end
      range_flat = '0;
      for (int i = 0; i < RANGE_SENSORS; i++) begin
         range_flat[8 * i +: 8] = range_in[i];
      end
   end

   assign frame_done = byte_valid && done;

   always_comb begin
      result.frame_result   = res_code;
      result.node_address   = hdr_cur[0];
      result.link_status    = hdr_cur[1][7:6];
      result.command_code   = hdr_cur[2];
      result.payload_length = hdr_cur[1][5:0];
      result.range_readings = range_flat;
      result.heading_raw    = heading_in;
      result.obstacle_flags = flag_in;
   end

   always_comb begin
      prev_in     = prev_ff;
      in_frame_in = in_frame_ff;
      idx_in      = idx_ff;
      total_in    = total_ff;
      sum_in      = sum_ff;
      for (int i = 0; i < HDR_DEPTH; i++) begin
         hdr_in[i] = hdr_ff[i];
      end
      for (int i = 0; i < STAGE_DEPTH; i++) begin
         stage_in[i] = stage_ff[i];
      end
      if (!in_frame_ff) begin
         if (byte_data == SYNC_SECOND && prev_ff == SYNC_FIRST) begin
            in_frame_in = 1'b1;
            prev_in     = '0;
            idx_in      = '0;
            total_in    = '0;
            sum_in      = SUM_SEED;
            for (int i = 0; i < STAGE_DEPTH; i++) begin
               stage_in[i] = '0;
            end
         end else begin
            prev_in = byte_data;
         end
      end else begin
         prev_in = '0;
         for (int i = 0; i < HDR_DEPTH; i++) begin
            hdr_in[i] = hdr_cur[i];
         end
         if (done) begin
            in_frame_in = 1'b0;
            idx_in      = '0;
            total_in    = '0;
            sum_in      = SUM_SEED;
            for (int i = 0; i < STAGE_DEPTH; i++) begin
               stage_in[i] = '0;
            end
         end else begin
            idx_in   = idx_next;
            total_in = total_cur;
            sum_in   = sum_ff + byte_data;
            for (int i = 0; i < STAGE_DEPTH; i++) begin
               stage_in[i] = stage_cur[i];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff     <= '0;
         in_frame_ff <= 1'b0;
         idx_ff      <= '0;
         total_ff    <= '0;
         sum_ff      <= SUM_SEED;
         heading_ff  <= '0;
         flag_ff     <= '0;
         for (int i = 0; i < HDR_DEPTH; i++) begin
            hdr_ff[i] <= '0;
         end
         for (int i = 0; i < STAGE_DEPTH; i++) begin
            stage_ff[i] <= '0;
         end
         for (int i = 0; i < RANGE_SENSORS; i++) begin
            range_ff[i] <= '0;
         end
      end else if (byte_take) begin
         prev_ff     <= prev_in;
         in_frame_ff <= in_frame_in;
         idx_ff      <= idx_in;
         total_ff    <= total_in;
         sum_ff      <= sum_in;
         for (int i = 0; i < HDR_DEPTH; i++) begin
            hdr_ff[i] <= hdr_in[i];
         end
         for (int i = 0; i < STAGE_DEPTH; i++) begin
            stage_ff[i] <= stage_in[i];
         end
         if (done && sum_ok) begin
            heading_ff <= heading_in;
            flag_ff    <= flag_in;
            for (int i = 0; i < RANGE_SENSORS; i++) begin
               range_ff[i] <= range_in[i];
            end
         end
      end
   end

   a_idle_clean: assert property (@(posedge clock) disable iff (reset)
      !in_frame_ff |-> (idx_ff == 7'd0 && total_ff == 7'd0 && sum_ff == SUM_SEED))
      else $error("parser counters not cleared outside a frame");

   a_total_known: assert property (@(posedge clock) disable iff (reset)
      (in_frame_ff && idx_ff >= 7'd2) |-> (total_ff >= LEN_EXTRA && idx_ff < total_ff))
      else $error("frame length not captured after length byte");

   a_result_code: assert property (@(posedge clock) disable iff (reset)
      frame_done |-> (result.frame_result == RES_ACCEPTED ||
                      result.frame_result == RES_CHECKSUM ||
                      result.frame_result == RES_UNKNOWN))
      else $error("invalid frame result code");

endmodule

@@ rtl/core/sfd_out_reg.sv @@
// Result register holding one finished frame report until the consumer takes it.
module sfd_out_reg
   import sfd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           load,
   input  sfd_result_type load_data,
   input  logic           take,
   output logic           full,
   output sfd_result_type data
);

   logic           valid_ff, valid_in;
   sfd_result_type data_ff;

   assign valid_in = load | (valid_ff & ~take);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= load_data;
      end
   end

   assign full = valid_ff;
   assign data = data_ff;

endmodule

@@ rtl/core/sensor_frame_deframer_core.sv @@
// Top level of the sensor frame deframer: input register, parser and result register.
// A byte on req_ is registered in the input register, then parsed and judged there, so
// a new byte is taken every cycle unless a stall holds that register. A frame report is
// loaded into the result register when its checksum byte is parsed, then shown on rsp_;
// the only stall is a frame end meeting a full result register not drained by rsp_tready.
module sensor_frame_deframer_core
   import sfd_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  logic [7:0]          req_tdata,  // rx_byte[7:0]
   output logic                rsp_tvalid,
   input  logic                rsp_tready,
   // frame_result[1:0], node_address[9:2], link_status[11:10], command_code[19:12],
   // payload_length[25:20], range_readings[89:26], heading_raw[105:90],
   // obstacle_flags[121:106], zeros[127:122]
   output logic [RSP_BITS-1:0] rsp_tdata
);

   logic           in_valid_ff, in_valid_in;
   logic [7:0]     in_byte_ff;
   logic           frame_done;
   logic           out_full;
   logic           out_room;
   logic           advance;
   sfd_result_type parsed;
   sfd_result_type held;

   assign out_room    = ~out_full | rsp_tready;
   assign advance     = in_valid_ff & (~frame_done | out_room);
   assign req_tready  = ~in_valid_ff | advance;
   assign in_valid_in = (req_tvalid & req_tready) | (in_valid_ff & ~advance);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_byte_ff <= req_tdata;
      end
   end

   sfd_parser u_parser (
      .clock      (clock),
      .reset      (reset),
      .byte_valid (in_valid_ff),
      .byte_data  (in_byte_ff),
      .byte_take  (advance),
      .frame_done (frame_done),
      .result     (parsed)
   );

   sfd_out_reg u_out (
      .clock     (clock),
      .reset     (reset),
      .load      (advance & frame_done),
      .load_data (parsed),
      .take      (rsp_tready),
      .full      (out_full),
      .data      (held)
   );

   assign rsp_tvalid = out_full;
   assign rsp_tdata  = {{(RSP_BITS - RESULT_BITS){1'b0}}, held.obstacle_flags,
                        held.heading_raw, held.range_readings, held.payload_length,
                        held.command_code, held.link_status, held.node_address,
                        held.frame_result};

   a_hold_on_stall: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && frame_done && out_full && !rsp_tready)
      |=> (in_valid_ff && $stable(in_byte_ff)))
      else $error("pending frame end lost while result register was full");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> (rsp_tvalid && $stable(rsp_tdata)))
      else $error("frame report changed while waiting for the consumer");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !in_valid_ff |-> req_tready)
      else $error("input refused while the input register was empty");

endmodule

@@ tb/testbench.sv @@
// Self-checking testbench for the sensor frame deframer core, driven by byte streams.
module testbench;
   timeunit 1ns;
   timeprecision 1ps;
   import sfd_pkg::*;

   localparam int unsigned RANDOM_BYTES = 1320;
   localparam int unsigned CYCLE_LIMIT  = 400000;
   localparam int unsigned HOLD_AFTER   = 25;
   localparam int unsigned HOLD_CYCLES  = 400;
   localparam int unsigned DRAIN_CYCLES = 20;
   localparam int unsigned ROW_COUNT    = 30;

   localparam logic [7:0] NOP_CODES [7] = '{CMD_NOP_21, CMD_NOP_24, CMD_NOP_25, CMD_NOP_26,
                                            CMD_NOP_2C, CMD_NOP_2D, CMD_NOP_2F};

   typedef struct {
      bit             typed;
      sfd_result_type report;
   } byte_note_type;

   typedef struct {
      logic [7:0]     rx;
      bit             typed;
      sfd_result_type report;
   } stim_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [7:0]          req_tdata = 8'h00;
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [RSP_BITS-1:0] rsp_tdata;

   byte_note_type  byte_notes[$];
   sfd_result_type pending_reports[$];
   int unsigned    failures = 0;
   int unsigned    cycle_count = 0;
   int unsigned    directed_bytes = 0;
   int unsigned    random_bytes = 0;
   int unsigned    report_tally [3] = '{default: 0};
   bit             req_calm = 1'b0;
   bit             rsp_calm = 1'b0;

   logic [7:0]  last_rx = 8'h00;
   bit          framing = 1'b0;
   logic [6:0]  body_idx = 7'd0;
   logic [6:0]  body_total = 7'd0;
   logic [7:0]  run_sum = SUM_SEED;
   logic [7:0]  hdr [HDR_DEPTH] = '{default: 8'h00};
   logic [7:0]  stage [STAGE_DEPTH] = '{default: 8'h00};
   logic [7:0]  ranges [8] = '{default: 8'h00};
   logic [15:0] heading = 16'h0000;
   logic [15:0] flags = 16'h0000;

   stim_row_type directed_rows [ROW_COUNT] = '{
      '{8'h55, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hFE, 1'b1, '{RES_UNKNOWN, 8'h00, 2'd0, 8'hFF, 6'd0, 64'd0, 16'd0, 16'd0}},
      '{8'h55, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'hFF, 1'b0, '0},
      '{8'hC0, 1'b0, '0},
      '{8'h21, 1'b0, '0},
      '{8'h00, 1'b1, '{RES_CHECKSUM, 8'hFF, 2'd3, 8'h21, 6'd0, 64'd0, 16'd0, 16'd0}},
      '{8'h55, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h01, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'h30, 1'b0, '0},
      '{8'h11, 1'b0, '0},
      '{8'h22, 1'b0, '0},
      '{8'h65, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h55, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h02, 1'b0, '0},
      '{8'h03, 1'b0, '0},
      '{8'h36, 1'b0, '0},
      '{8'h55, 1'b0, '0},
      '{8'hAA, 1'b0, '0},
      '{8'h00, 1'b0, '0},
      '{8'h39, 1'b0, '0}
   };

   sensor_frame_deframer_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #6 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles.", cycle_count);
         $display("FAIL");
         $finish;
      end
   end

   function automatic int unsigned pick_wait(inout bit calm);
      if ($urandom_range(0, 39) == 0) calm = ~calm;
      return calm ? 0 : $urandom_range(0, 19);
   endfunction

   task automatic restart_frame_state();
      foreach (stage[i]) stage[i] = 8'h00;
      body_idx   = 7'd0;
      body_total = 7'd0;
      run_sum    = SUM_SEED;
      last_rx    = 8'h00;
   endtask

   task automatic parse_rx_byte(input logic [7:0] rx, output bit done,
                                output sfd_result_type rep);
      frame_result_type verdict;
      logic [63:0]      packed_ranges;
      done = 1'b0;
      rep  = '0;
      if (!framing) begin
         if (rx == SYNC_SECOND && last_rx == SYNC_FIRST) begin
            restart_frame_state();
            framing = 1'b1;
         end else begin
            last_rx = rx;
         end
         return;
      end
      last_rx = 8'h00;
      if (body_idx < HDR_DEPTH) begin
         hdr[body_idx] = rx;
      end else if (body_idx - HDR_DEPTH < STAGE_DEPTH) begin
         stage[body_idx - HDR_DEPTH] = rx;
      end
      if (body_idx == 7'd1) body_total = {1'b0, rx[5:0]} + LEN_EXTRA;
      body_idx = body_idx + 7'd1;
      if (body_idx != body_total) begin
         run_sum = run_sum + rx;
         return;
      end
      verdict = RES_ACCEPTED;
      if (rx != run_sum) begin
         verdict = RES_CHECKSUM;
      end else begin
         case (hdr[2])
            CMD_RANGE: begin
               for (int i = 0; i < RANGE_SENSORS; i++) ranges[i] = stage[i];
            end
            CMD_HEADING: begin
               heading = {stage[2], stage[3]};
            end
            CMD_FLAGS: begin
               for (int i = 0; i < FLAG_BYTES; i++)
                  for (int k = 0; k < 8; k++) flags[8*i+7-k] = ~stage[i][k];
            end
            CMD_NOP_21, CMD_NOP_24, CMD_NOP_25, CMD_NOP_26,
            CMD_NOP_2C, CMD_NOP_2D, CMD_NOP_2F: begin
               verdict = RES_ACCEPTED;
            end
            default: begin
               verdict = RES_UNKNOWN;
            end
         endcase
      end
      for (int i = 0; i < 8; i++) packed_ranges[8*i +: 8] = ranges[i];
      rep.frame_result   = verdict;
      rep.node_address   = hdr[0];
      rep.link_status    = hdr[1][7:6];
      rep.command_code   = hdr[2];
      rep.payload_length = hdr[1][5:0];
      rep.range_readings = packed_ranges;
      rep.heading_raw    = heading;
      rep.obstacle_flags = flags;
      done = 1'b1;
      restart_frame_state();
      framing = 1'b0;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, name, want, got);
         failures++;
      end
   endtask

   always @(posedge clock) begin : monitor
      sfd_result_type seen;
      sfd_result_type want;
      sfd_result_type guess;
      byte_note_type  note;
      bit             done;
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen.frame_result   = frame_result_type'(rsp_tdata[1:0]);
         seen.node_address   = rsp_tdata[9:2];
         seen.link_status    = rsp_tdata[11:10];
         seen.command_code   = rsp_tdata[19:12];
         seen.payload_length = rsp_tdata[25:20];
         seen.range_readings = rsp_tdata[89:26];
         seen.heading_raw    = rsp_tdata[105:90];
         seen.obstacle_flags = rsp_tdata[121:106];
         if (pending_reports.size() == 0) begin
            $display("%0t: unexpected frame report, expected none, got 0x%0h", $time,
                     rsp_tdata);
            failures++;
         end else begin
            want = pending_reports.pop_front();
            check_field("frame_result", 64'(want.frame_result), 64'(seen.frame_result));
            check_field("node_address", 64'(want.node_address), 64'(seen.node_address));
            check_field("link_status", 64'(want.link_status), 64'(seen.link_status));
            check_field("command_code", 64'(want.command_code), 64'(seen.command_code));
            check_field("payload_length", 64'(want.payload_length),
                        64'(seen.payload_length));
            check_field("range_readings", want.range_readings, seen.range_readings);
            check_field("heading_raw", 64'(want.heading_raw), 64'(seen.heading_raw));
            check_field("obstacle_flags", 64'(want.obstacle_flags),
                        64'(seen.obstacle_flags));
            report_tally[int'(want.frame_result)]++;
         end
      end
      if (!reset && req_tvalid && req_tready) begin
         note = byte_notes.pop_front();
         parse_rx_byte(req_tdata, done, guess);
         if (done) pending_reports.push_back(note.typed ? note.report : guess);
      end
   end

   task automatic offer_byte(input logic [7:0] rx, input bit typed,
                             input sfd_result_type rep);
      int unsigned gap;
      gap = pick_wait(req_calm);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      byte_notes.push_back(byte_note_type'{typed, rep});
      req_tvalid <= 1'b1;
      req_tdata  <= rx;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic send_random_frame();
      logic [7:0]  body[$];
      logic [7:0]  sum;
      int unsigned plen;
      int unsigned pick;
      int unsigned cut;
      int unsigned junk;
      junk = $urandom_range(0, 2);
      repeat (junk) offer_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      pick = $urandom_range(0, 99);
      if (pick < 5) plen = $urandom_range(11, 63);
      else if (pick < 7) plen = 63;
      else plen = $urandom_range(0, 10);
      body.push_back(8'($urandom_range(0, 255)));
      body.push_back({2'($urandom_range(0, 3)), 6'(plen)});
      pick = $urandom_range(0, 15);
      if (pick < 3) body.push_back(CMD_RANGE);
      else if (pick < 5) body.push_back(CMD_HEADING);
      else if (pick < 8) body.push_back(CMD_FLAGS);
      else if (pick < 13) body.push_back(NOP_CODES[$urandom_range(0, 6)]);
      else body.push_back(8'($urandom_range(0, 255)));
      while (body.size() < plen + 3) begin
         if (body.size() + 2 <= plen + 3 && $urandom_range(0, 5) == 0) begin
            body.push_back(SYNC_FIRST);
            body.push_back(SYNC_SECOND);
         end else begin
            body.push_back(8'($urandom_range(0, 255)));
         end
      end
      sum = SUM_SEED;
      foreach (body[i]) sum = sum + body[i];
      if ($urandom_range(0, 7) == 0) sum = sum ^ 8'($urandom_range(1, 255));
      body.push_back(sum);
      cut = body.size();
      if ($urandom_range(0, 29) == 0) cut = $urandom_range(1, body.size() - 1);
      offer_byte(SYNC_FIRST, 1'b0, '0);
      offer_byte(SYNC_SECOND, 1'b0, '0);
      for (int i = 0; i < cut; i++) offer_byte(body[i], 1'b0, '0);
      random_bytes += junk + cut + 2;
   endtask

   initial begin : receiver
      int unsigned stall;
      int unsigned taken;
      taken = 0;
      while (reset) @(posedge clock);
      forever begin
         if (taken == HOLD_AFTER) begin
            rsp_tready <= 1'b0;
            for (int c = 0; c < HOLD_CYCLES; c++) @(posedge clock);
         end else begin
            stall = pick_wait(rsp_calm);
            if (stall > 0) begin
               rsp_tready <= 1'b0;
               repeat (stall) @(posedge clock);
            end
         end
         rsp_tready <= 1'b1;
         @(posedge clock);
         while (!rsp_tvalid) @(posedge clock);
         taken++;
      end
   end

   initial begin : sender
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      foreach (directed_rows[i]) begin
         offer_byte(directed_rows[i].rx, directed_rows[i].typed, directed_rows[i].report);
         directed_bytes++;
      end
      while (random_bytes < RANDOM_BYTES) send_random_frame();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending_reports.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Covered %0d directed and %0d random frame bytes in %0d cycles.",
               directed_bytes, random_bytes, cycle_count);
      $display("Frame reports: %0d accepted, %0d checksum errors, %0d unknown commands.",
               report_tally[0], report_tally[1], report_tally[2]);
      if (failures == 0) begin
         $display("PASS");
      end else begin
         $display("FAIL");
      end
      $finish;
   end

endmodule
